FILE: design/parity_priority_compressor_core_defines.svh
// Assertion macros for the parity priority compressor.
// Included by files that carry concurrent assertions; needs no other file.
`ifndef PARITY_PRIORITY_COMPRESSOR_CORE_DEFINES_SVH
`define PARITY_PRIORITY_COMPRESSOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PPC_ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
		else $error("ppc assertion failed");
`define PPC_ASSERT_NXT(label, clk_sig, rstn_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
		else $error("ppc assertion failed");
`else
`define PPC_ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons)
`define PPC_ASSERT_NXT(label, clk_sig, rstn_sig, ante, cons)
`endif
`endif

FILE: design/ppc_pkg.sv
// Shared types and constants of the parity priority compressor.
// Used by every module of the block; depends on nothing.
package ppc_pkg;

	localparam int PRIO_W = 8;
	localparam int LIMIT_W = 9;
	localparam int TOTAL_W = 32;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;
	localparam int MAP_W = PRIO_W + 1;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] CMD_COUNT = 2'd0;
	localparam logic [1:0] CMD_COMPUTE = 2'd1;
	localparam logic [1:0] CMD_REMAP = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_VERTEX = 1'b1;

	localparam logic [1:0] REG_NUM = 2'd0;
	localparam logic [1:0] REG_PRESERVE = 2'd1;
	localparam logic [1:0] REG_DUAL = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [PRIO_W-1:0] vertex_priority;
		logic vertex_player;
	} req_t;

	typedef struct packed {
		logic result_kind;
		logic [PRIO_W-1:0] out_priority;
		logic out_player;
		logic [LIMIT_W-1:0] priority_limit;
		logic compressed;
	} rsp_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] limit;
		logic parity_keep;
		logic dual_mode;
	} cfg_t;

	typedef struct packed {
		logic [1:0] command;
		logic [PRIO_W-1:0] prio;
		logic player;
		logic [LIMIT_W-1:0] eff_prio;
		logic eff_player;
		logic in_range;
	} op_t;

endpackage

FILE: design/ppc_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Used by all modules of the compressor; depends on nothing.
interface ppc_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: design/ppc_front.sv
// Front end: accepts requests and classifies them for the back end.
// Depends on ppc_pkg and ppc_stream_if.
module ppc_front (
	input ppc_pkg::cfg_t cfg,
	input logic init_busy,
	ppc_stream_if.sink req,
	ppc_stream_if.source op_out
);

	logic [ppc_pkg::LIMIT_W-1:0] eff_prio;
	ppc_pkg::op_t op;

	always_comb begin
		eff_prio = {1'b0, req.payload.vertex_priority} + {{(ppc_pkg::LIMIT_W-1){1'b0}}, cfg.dual_mode};
		op.command = req.payload.command;
		op.prio = req.payload.vertex_priority;
		op.player = req.payload.vertex_player;
		op.eff_prio = eff_prio;
		op.eff_player = req.payload.vertex_player ^ cfg.dual_mode;
		op.in_range = eff_prio < cfg.limit;
	end

	assign op_out.payload = op;
	assign op_out.valid = req.valid & ~init_busy;
	assign req.ready = op_out.ready & ~init_busy;

endmodule

FILE: design/ppc_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on ppc_pkg and ppc_stream_if.
module ppc_queue (
	input logic clk,
	input logic arst_n,
	ppc_stream_if.sink op_in,
	ppc_stream_if.source op_out
);

	localparam int QPW = $clog2(ppc_pkg::QUEUE_DEPTH);

	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QPW:0] count_q;
	ppc_pkg::op_t entry_q [ppc_pkg::QUEUE_DEPTH];
	logic push;
	logic pop;

	assign op_in.ready = count_q != (QPW+1)'(ppc_pkg::QUEUE_DEPTH);
	assign op_out.valid = count_q != '0;
	assign op_out.payload = entry_q[rd_ptr_q];
	assign push = op_in.valid & op_in.ready;
	assign pop = op_out.valid & op_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			count_q <= count_q + (QPW+1)'(push) - (QPW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= op_in.payload;
		end
	end

endmodule

FILE: design/ppc_back.sv
// Back end: histogram and map memories, compute sequencer and result register.
// Depends on ppc_pkg and ppc_stream_if.
module ppc_back #(
	parameter int MAX_PRIORITIES = 256,
	parameter int COUNT_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input ppc_pkg::cfg_t cfg,
	output logic init_busy,
	ppc_stream_if.sink op_in,
	ppc_stream_if.source rsp
);

	localparam int PW = $clog2(MAX_PRIORITIES);
	localparam int CW = PW + 1;
	localparam int EW = (CW > ppc_pkg::LIMIT_W) ? CW : ppc_pkg::LIMIT_W;

	localparam logic [3:0] ST_SWEEP = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_CNT = 4'd2;
	localparam logic [3:0] ST_RMP = 4'd3;
	localparam logic [3:0] ST_SCAN = 4'd4;
	localparam logic [3:0] ST_MAP = 4'd5;
	localparam logic [3:0] ST_FLUSH = 4'd6;
	localparam logic [3:0] ST_EMIT = 4'd7;

	logic [COUNT_BITS-1:0] hist_mem [MAX_PRIORITIES];
	logic [ppc_pkg::MAP_W-1:0] map_mem [MAX_PRIORITIES];
	logic [COUNT_BITS-1:0] hist_rdata_q;
	logic [ppc_pkg::MAP_W-1:0] map_rdata_q;

	logic hist_we;
	logic [PW-1:0] hist_waddr;
	logic [PW-1:0] hist_raddr;
	logic [COUNT_BITS-1:0] hist_wdata;
	logic map_we;
	logic [PW-1:0] map_waddr;
	logic [PW-1:0] map_raddr;
	logic [ppc_pkg::MAP_W-1:0] map_wdata;

	logic [3:0] state_q, state_d;
	logic init_q, init_d;
	logic [CW-1:0] idx_q, idx_d;
	logic pend_q, pend_d;
	logic [CW-1:0] pidx_q, pidx_d;
	ppc_pkg::op_t cur_q, cur_d;
	logic map_ready_q, map_ready_d;
	logic swap_q, swap_d;
	logic [ppc_pkg::TOTAL_W-1:0] total_q, total_d;
	logic has_zero_q, has_zero_d;
	logic found_q, found_d;
	logic [CW-1:0] first_q, first_d;
	logic [CW-1:0] last_q, last_d;
	logic [COUNT_BITS-1:0] acc_q, acc_d;
	logic ident_q, ident_d;
	ppc_pkg::rsp_t res_q, res_d;
	logic out_valid_q, out_valid_d;
	ppc_pkg::rsp_t out_q, out_d;

	logic [CW-1:0] d_cw;
	logic [CW-1:0] last_inc;
	logic [COUNT_BITS:0] merge_sum;
	logic [COUNT_BITS-1:0] merged;

	assign d_cw = CW'(cfg.limit);
	assign last_inc = last_q + CW'(1);
	assign merge_sum = {1'b0, acc_q} + {1'b0, hist_rdata_q};
	assign merged = merge_sum[COUNT_BITS] ? '1 : merge_sum[COUNT_BITS-1:0];

	assign init_busy = init_q;
	assign op_in.ready = state_q == ST_IDLE;
	assign rsp.valid = out_valid_q;
	assign rsp.payload = out_q;

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		hist_rdata_q <= hist_mem[hist_raddr];
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		map_rdata_q <= map_mem[map_raddr];
	end

	always_comb begin
		state_d = state_q;
		init_d = init_q;
		idx_d = idx_q;
		pend_d = pend_q;
		pidx_d = pidx_q;
		cur_d = cur_q;
		map_ready_d = map_ready_q;
		swap_d = swap_q;
		total_d = total_q;
		has_zero_d = has_zero_q;
		found_d = found_q;
		first_d = first_q;
		last_d = last_q;
		acc_d = acc_q;
		ident_d = ident_q;
		res_d = res_q;
		out_valid_d = out_valid_q & ~rsp.ready;
		out_d = out_q;
		hist_we = 1'b0;
		hist_waddr = idx_q[PW-1:0];
		hist_wdata = '0;
		hist_raddr = idx_q[PW-1:0];
		map_we = 1'b0;
		map_waddr = pidx_q[PW-1:0];
		map_wdata = '0;
		map_raddr = PW'(op_in.payload.eff_prio);

		case (state_q)
			ST_SWEEP: begin
				hist_we = 1'b1;
				if (idx_q == CW'(MAX_PRIORITIES - 1)) begin
					init_d = 1'b0;
					if (init_q || cur_q.command == ppc_pkg::CMD_CLEAR) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_EMIT;
					end
				end else begin
					idx_d = idx_q + CW'(1);
				end
			end
			ST_IDLE: begin
				if (op_in.valid) begin
					cur_d = op_in.payload;
					case (op_in.payload.command)
						ppc_pkg::CMD_COUNT: begin
							hist_raddr = PW'(op_in.payload.eff_prio);
							if (op_in.payload.in_range) begin
								state_d = ST_CNT;
							end
						end
						ppc_pkg::CMD_COMPUTE: begin
							idx_d = '0;
							pend_d = 1'b0;
							has_zero_d = 1'b0;
							found_d = 1'b0;
							first_d = '0;
							state_d = ST_SCAN;
						end
						ppc_pkg::CMD_REMAP: begin
							res_d.result_kind = ppc_pkg::KIND_VERTEX;
							res_d.priority_limit = '0;
							res_d.compressed = 1'b0;
							if (!map_ready_q) begin
								res_d.out_priority = op_in.payload.prio;
								res_d.out_player = op_in.payload.player;
								state_d = ST_EMIT;
							end else if (EW'(op_in.payload.eff_prio) < EW'(MAX_PRIORITIES)) begin
								state_d = ST_RMP;
							end else begin
								res_d.out_priority = op_in.payload.eff_prio[ppc_pkg::PRIO_W-1:0];
								res_d.out_player = op_in.payload.eff_player ^ swap_q;
								state_d = ST_EMIT;
							end
						end
						ppc_pkg::CMD_CLEAR: begin
							total_d = '0;
							idx_d = '0;
							state_d = ST_SWEEP;
						end
						default: begin
						end
					endcase
				end
			end
			ST_CNT: begin
				hist_we = 1'b1;
				hist_waddr = PW'(cur_q.eff_prio);
				hist_wdata = (&hist_rdata_q) ? hist_rdata_q : hist_rdata_q + COUNT_BITS'(1);
				if (!(&total_q)) begin
					total_d = total_q + ppc_pkg::TOTAL_W'(1);
				end
				state_d = ST_IDLE;
			end
			ST_RMP: begin
				if (map_rdata_q[ppc_pkg::MAP_W-1]) begin
					res_d.out_priority = map_rdata_q[ppc_pkg::PRIO_W-1:0];
				end else begin
					res_d.out_priority = cur_q.eff_prio[ppc_pkg::PRIO_W-1:0];
				end
				res_d.out_player = cur_q.eff_player ^ swap_q;
				state_d = ST_EMIT;
			end
			ST_SCAN: begin
				if (idx_q < d_cw) begin
					idx_d = idx_q + CW'(1);
					pend_d = 1'b1;
					pidx_d = idx_q;
				end else begin
					pend_d = 1'b0;
				end
				if (pend_q) begin
					if (hist_rdata_q == '0) begin
						if (pidx_q >= CW'(cfg.parity_keep)) begin
							has_zero_d = 1'b1;
						end
					end else if (!found_q) begin
						found_d = 1'b1;
						first_d = pidx_q;
					end
				end else if (idx_q >= d_cw) begin
					ident_d = (total_q == '0) || !has_zero_q ||
						(!cfg.parity_keep && !found_q);
					if (cfg.parity_keep) begin
						first_d = '0;
					end
					last_d = '0;
					acc_d = '0;
					idx_d = '0;
					pend_d = 1'b0;
					state_d = ST_MAP;
				end
			end
			ST_MAP: begin
				if (idx_q < CW'(MAX_PRIORITIES)) begin
					idx_d = idx_q + CW'(1);
					pend_d = 1'b1;
					pidx_d = idx_q;
				end else begin
					pend_d = 1'b0;
				end
				if (pend_q) begin
					map_we = 1'b1;
					if (ident_q) begin
						map_wdata = {pidx_q < d_cw, ppc_pkg::PRIO_W'(pidx_q)};
					end else if (pidx_q == first_q) begin
						map_wdata = {1'b1, {ppc_pkg::PRIO_W{1'b0}}};
						acc_d = hist_rdata_q;
						last_d = '0;
					end else if (pidx_q > first_q && pidx_q < d_cw && hist_rdata_q != '0) begin
						if ((last_q[0] ^ pidx_q[0]) != first_q[0]) begin
							hist_we = 1'b1;
							hist_waddr = last_q[PW-1:0];
							hist_wdata = acc_q;
							last_d = last_inc;
							acc_d = hist_rdata_q;
							map_wdata = {1'b1, ppc_pkg::PRIO_W'(last_inc)};
						end else begin
							acc_d = merged;
							map_wdata = {1'b1, ppc_pkg::PRIO_W'(last_q)};
						end
					end else begin
						map_wdata = '0;
					end
				end else if (idx_q == CW'(MAX_PRIORITIES)) begin
					if (ident_q) begin
						res_d.result_kind = ppc_pkg::KIND_SUMMARY;
						res_d.out_priority = '0;
						res_d.out_player = 1'b0;
						res_d.priority_limit = cfg.limit;
						res_d.compressed = 1'b0;
						swap_d = 1'b0;
						map_ready_d = 1'b1;
						state_d = ST_EMIT;
					end else begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				hist_we = 1'b1;
				hist_waddr = last_q[PW-1:0];
				hist_wdata = acc_q;
				swap_d = first_q[0];
				map_ready_d = 1'b1;
				res_d.result_kind = ppc_pkg::KIND_SUMMARY;
				res_d.out_priority = '0;
				res_d.out_player = 1'b0;
				res_d.priority_limit = ppc_pkg::LIMIT_W'(last_inc);
				res_d.compressed = 1'b1;
				idx_d = last_inc;
				if (last_inc == CW'(MAX_PRIORITIES)) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_SWEEP;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || rsp.ready) begin
					out_valid_d = 1'b1;
					out_d = res_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			init_q <= 1'b1;
			idx_q <= '0;
			pend_q <= 1'b0;
			map_ready_q <= 1'b0;
			swap_q <= 1'b0;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			init_q <= init_d;
			idx_q <= idx_d;
			pend_q <= pend_d;
			map_ready_q <= map_ready_d;
			swap_q <= swap_d;
			total_q <= total_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pidx_q <= pidx_d;
		cur_q <= cur_d;
		has_zero_q <= has_zero_d;
		found_q <= found_d;
		first_q <= first_d;
		last_q <= last_d;
		acc_q <= acc_d;
		ident_q <= ident_d;
		res_q <= res_d;
		out_q <= out_d;
	end

endmodule

FILE: design/parity_priority_compressor_core.sv
// Top level of the parity priority compressor: configuration registers and wiring.
// Depends on ppc_pkg, ppc_stream_if, ppc_front, ppc_queue, ppc_back and the defines header.
//
// Requests enter on req (command, vertex_priority, vertex_player) and results
// leave on rsp; both are valid/ready channels. Count and clear requests give no
// result, compute and remap requests give exactly one, in request order.
// Configuration registers sit on the APB port at byte addresses 0, 4 and 8.
// The user must see that they are written only while the block is idle; the
// block does not enforce it. The front end passes a request into a two-entry
// queue in the cycle it is offered whenever the queue has room, once the
// reset sweep is over. A count reads its histogram entry and writes it back
// incremented, or does nothing if its priority is out of range. A remap
// reads the map and then loads the result register, or loads it at once
// before the first compute or for a priority beyond the map. A clear sweeps
// the whole histogram. A compute scans the histogram up to the effective
// number of priorities, then writes the map over all entries; when it
// compresses, it flushes the last merged count and clears the histogram
// above the new limit. After reset a clearing pass empties the histogram,
// and req stays not ready until it ends.
// A result waits in the output register while rsp is stalled; counts and clears
// behind it keep going, and a further result stalls the back end until taken.
`include "parity_priority_compressor_core_defines.svh"

module parity_priority_compressor_core #(
	parameter int MAX_PRIORITIES = 256,
	parameter int COUNT_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ppc_pkg::ADDR_W-1:0] paddr,
	input logic [ppc_pkg::DATA_W-1:0] pwdata,
	output logic [ppc_pkg::DATA_W-1:0] prdata,
	output logic pready,
	ppc_stream_if.sink req,
	ppc_stream_if.source rsp
);

	logic [ppc_pkg::PRIO_W-1:0] num_q;
	logic preserve_q;
	logic dual_q;
	logic [1:0] reg_index;
	logic [ppc_pkg::LIMIT_W-1:0] limit_sum;
	ppc_pkg::cfg_t cfg;
	logic init_busy;

	ppc_stream_if #(.payload_t(ppc_pkg::op_t)) front_if ();
	ppc_stream_if #(.payload_t(ppc_pkg::op_t)) back_if ();

	assign pready = 1'b1;
	assign reg_index = paddr[ppc_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= ppc_pkg::PRIO_W'(1);
			preserve_q <= 1'b0;
			dual_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_index)
				ppc_pkg::REG_NUM: num_q <= pwdata[ppc_pkg::PRIO_W-1:0];
				ppc_pkg::REG_PRESERVE: preserve_q <= pwdata[0];
				ppc_pkg::REG_DUAL: dual_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			ppc_pkg::REG_NUM: prdata = {{(ppc_pkg::DATA_W-ppc_pkg::PRIO_W){1'b0}}, num_q};
			ppc_pkg::REG_PRESERVE: prdata = {{(ppc_pkg::DATA_W-1){1'b0}}, preserve_q};
			ppc_pkg::REG_DUAL: prdata = {{(ppc_pkg::DATA_W-1){1'b0}}, dual_q};
			default: prdata = '0;
		endcase
	end

	always_comb begin
		limit_sum = {1'b0, num_q} + {{(ppc_pkg::LIMIT_W-1){1'b0}}, dual_q};
		if (32'(limit_sum) > 32'(MAX_PRIORITIES)) begin
			cfg.limit = ppc_pkg::LIMIT_W'(MAX_PRIORITIES);
		end else begin
			cfg.limit = limit_sum;
		end
		cfg.parity_keep = preserve_q;
		cfg.dual_mode = dual_q;
	end

	ppc_front u_front (
		.cfg(cfg),
		.init_busy(init_busy),
		.req(req),
		.op_out(front_if)
	);

	ppc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.op_in(front_if),
		.op_out(back_if)
	);

	ppc_back #(
		.MAX_PRIORITIES(MAX_PRIORITIES),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.init_busy(init_busy),
		.op_in(back_if),
		.rsp(rsp)
	);

	// No request is taken during the clearing pass after reset.
	`PPC_ASSERT_IMP(a_no_accept_in_init, clk, arst_n, init_busy,
		!(req.valid && req.ready))
	`PPC_ASSERT_IMP(a_summary_fields, clk, arst_n,
		rsp.valid && rsp.payload.result_kind == ppc_pkg::KIND_SUMMARY,
		rsp.payload.out_priority == '0 && !rsp.payload.out_player &&
		rsp.payload.priority_limit <= cfg.limit)
	`PPC_ASSERT_IMP(a_vertex_fields, clk, arst_n,
		rsp.valid && rsp.payload.result_kind == ppc_pkg::KIND_VERTEX,
		rsp.payload.priority_limit == '0 && !rsp.payload.compressed)
	// A count leaves the result register untouched.
	`PPC_ASSERT_NXT(a_count_silent, clk, arst_n,
		back_if.valid && back_if.ready && back_if.payload.command == ppc_pkg::CMD_COUNT &&
		!rsp.valid, !rsp.valid)

endmodule
